/* rtl/hdc_pkg.sv */
// Shared types, constants and lookup functions for the HSV dominant color classifier.
// No dependencies; imported by every module of the block.
`default_nettype none
package hdc_pkg;

	localparam int FRAME_PIXEL_BITS_DEF = 24;
	localparam int SUM_BITS_DEF         = 16 + FRAME_PIXEL_BITS_DEF;
	localparam int NUM_HUE_CLASSES      = 6;

	// configuration register indexes
	localparam logic [1:0] REG_DARK_VALUE_LIMIT       = 2'd0;
	localparam logic [1:0] REG_SATURATION_LINE_OFFSET = 2'd1;
	localparam logic [1:0] REG_WHITE_VALUE_LIMIT      = 2'd2;

	localparam logic [7:0] DARK_VALUE_LIMIT_RST       = 8'd45;
	localparam logic [7:0] SATURATION_LINE_OFFSET_RST = 8'd113;
	localparam logic [7:0] WHITE_VALUE_LIMIT_RST      = 8'd164;

	// inclusive upper bounds of the hue bands
	localparam logic [7:0] HUE_RED_LO_MAX  = 8'd15;
	localparam logic [7:0] HUE_YELLOW_MAX  = 8'd51;
	localparam logic [7:0] HUE_GREEN_MAX   = 8'd97;
	localparam logic [7:0] HUE_CYAN_MAX    = 8'd143;
	localparam logic [7:0] HUE_BLUE_MAX    = 8'd182;
	localparam logic [7:0] HUE_MAGENTA_MAX = 8'd230;

	typedef enum logic [2:0] {
		CLS_BLACK   = 3'd0,
		CLS_BLUE    = 3'd1,
		CLS_GREEN   = 3'd2,
		CLS_CYAN    = 3'd3,
		CLS_RED     = 3'd4,
		CLS_MAGENTA = 3'd5,
		CLS_YELLOW  = 3'd6,
		CLS_WHITE   = 3'd7
	} color_t;

	typedef struct packed {
		logic [7:0] dark_value_limit;
		logic [7:0] saturation_line_offset;
		logic [7:0] white_value_limit;
	} cfg_t;

	function automatic color_t hue_band(input logic [7:0] h);
		color_t c;
		if (h <= HUE_RED_LO_MAX)       c = CLS_RED;
		else if (h <= HUE_YELLOW_MAX)  c = CLS_YELLOW;
		else if (h <= HUE_GREEN_MAX)   c = CLS_GREEN;
		else if (h <= HUE_CYAN_MAX)    c = CLS_CYAN;
		else if (h <= HUE_BLUE_MAX)    c = CLS_BLUE;
		else if (h <= HUE_MAGENTA_MAX) c = CLS_MAGENTA;
		else                           c = CLS_RED;
		return c;
	endfunction

	function automatic logic [7:0] class_hue(input color_t c);
		logic [7:0] h;
		unique case (c)
			CLS_BLUE:    h = 8'd170;
			CLS_GREEN:   h = 8'd85;
			CLS_CYAN:    h = 8'd128;
			CLS_MAGENTA: h = 8'd213;
			CLS_YELLOW:  h = 8'd43;
			default:     h = 8'd0;
		endcase
		return h;
	endfunction

	function automatic logic is_hue_class(input color_t c);
		return (c != CLS_BLACK) && (c != CLS_WHITE);
	endfunction

endpackage
`default_nettype wire

/* rtl/hdc_classify.sv */
// Input register and classification stage: black / white / hue band and the s*v weight.
// Depends on hdc_pkg.
`default_nettype none
module hdc_classify
	import hdc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_vld,
	output logic            in_rdy,
	input  wire logic [7:0] hue,
	input  wire logic [7:0] saturation,
	input  wire logic [7:0] brightness,
	input  wire logic       frame_end,
	output logic            vld_s2,
	input  wire logic       rdy_next,
	output color_t          cls_s2,
	output logic [15:0]     weight_s2,
	output logic            last_s2
);

	logic       vld_s1;
	logic [7:0] hue_s1;
	logic [7:0] sat_s1;
	logic [7:0] bri_s1;
	logic       last_s1;
	logic       rdy_s1;
	logic       rdy_s2;
	logic [9:0] line_lhs;
	logic [9:0] line_rhs;
	color_t     cls_c;

	assign rdy_s2 = !vld_s2 || rdy_next;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_vld) begin
			hue_s1  <= hue;
			sat_s1  <= saturation;
			bri_s1  <= brightness;
			last_s1 <= frame_end;
		end
		if (rdy_s2 && vld_s1) begin
			cls_s2    <= cls_c;
			weight_s2 <= sat_s1 * bri_s1;
			last_s2   <= last_s1;
		end
	end

	// 3*sat + val against 3*offset, all in 10 bits
	assign line_lhs = {1'b0, sat_s1, 1'b0} + {2'b00, sat_s1} + {2'b00, bri_s1};
	assign line_rhs = {1'b0, cfg.saturation_line_offset, 1'b0}
		+ {2'b00, cfg.saturation_line_offset};

	always_comb begin
		if (bri_s1 <= cfg.dark_value_limit)
			cls_c = CLS_BLACK;
		else if (line_lhs > line_rhs)
			cls_c = hue_band(hue_s1);
		else if (bri_s1 > cfg.white_value_limit)
			cls_c = CLS_WHITE;
		else
			cls_c = CLS_BLACK;
	end

endmodule
`default_nettype wire

/* rtl/hdc_accum.sv */
// Per-class saturating weight accumulators; snapshots and clears them on a frame's last pixel.
// Depends on hdc_pkg.
`default_nettype none
module hdc_accum
	import hdc_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    vld_in,
	output logic                                         rdy_in,
	input  wire color_t                                  cls_in,
	input  wire logic [15:0]                             weight_in,
	input  wire logic                                    last_in,
	output logic                                         vld_s3,
	input  wire logic                                    rdy_next,
	output color_t                                       cls_s3,
	output logic                                         last_s3,
	output logic [NUM_HUE_CLASSES-1:0][SUM_BITS-1:0]     sums_s3
);

	logic [NUM_HUE_CLASSES-1:0][SUM_BITS-1:0] acc_q;
	logic [NUM_HUE_CLASSES-1:0][SUM_BITS-1:0] acc_nxt;
	logic [2:0]                               slot;
	logic                                     hue_cls;
	logic [SUM_BITS-1:0]                      acc_sel;
	logic [SUM_BITS:0]                        acc_sum;
	logic [SUM_BITS-1:0]                      acc_sat;
	logic                                     take;

	assign rdy_in = !vld_s3 || rdy_next;
	assign take   = vld_in && rdy_in;

	assign hue_cls = is_hue_class(cls_in);
	assign slot    = 3'(cls_in) - 3'd1;
	assign acc_sel = hue_cls ? acc_q[slot] : '0;
	assign acc_sum = {1'b0, acc_sel} + {{(SUM_BITS-15){1'b0}}, weight_in};
	// clamp at all ones on carry out
	assign acc_sat = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];

	always_comb begin
		for (int i = 0; i < NUM_HUE_CLASSES; i++) begin
			acc_nxt[i] = (hue_cls && slot == 3'(i)) ? acc_sat : acc_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			acc_q  <= '0;
		end else begin
			if (rdy_in) vld_s3 <= vld_in;
			if (take) acc_q <= last_in ? '0 : acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s3  <= cls_in;
			last_s3 <= last_in;
			if (last_in) sums_s3 <= acc_nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/hdc_argmax.sv */
// Three-stage registered compare tree picking the largest class sum, lowest class on ties.
// Depends on hdc_pkg; its last stage is the block's output register.
`default_nettype none
module hdc_argmax
	import hdc_pkg::*;
#(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    vld_in,
	output logic                                         rdy_in,
	input  wire color_t                                  cls_in,
	input  wire logic                                    last_in,
	input  wire logic [NUM_HUE_CLASSES-1:0][SUM_BITS-1:0] sums_in,
	output logic                                         vld_s6,
	input  wire logic                                    rdy_next,
	output color_t                                       cls_s6,
	output logic                                         last_s6,
	output logic [2:0]                                   dom_s6
);

	logic                vld_s4, vld_s5;
	logic                rdy_s4, rdy_s5, rdy_s6;
	color_t              cls_s4, cls_s5;
	logic                last_s4, last_s5;
	logic [SUM_BITS-1:0] a_s4, b_s4, c_s4;
	logic [2:0]          ia_s4, ib_s4, ic_s4;
	logic [SUM_BITS-1:0] w_s5, c_s5;
	logic [2:0]          iw_s5, ic_s5;
	logic [2:0]          win_c;

	assign rdy_s6 = !vld_s6 || rdy_next;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_in = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= vld_in;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// the higher slot wins only on a strictly larger sum
	assign win_c = (c_s5 > w_s5) ? ic_s5 : iw_s5;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_in) begin
			cls_s4  <= cls_in;
			last_s4 <= last_in;
			{a_s4, ia_s4} <= (sums_in[1] > sums_in[0]) ? {sums_in[1], 3'd1} : {sums_in[0], 3'd0};
			{b_s4, ib_s4} <= (sums_in[3] > sums_in[2]) ? {sums_in[3], 3'd3} : {sums_in[2], 3'd2};
			{c_s4, ic_s4} <= (sums_in[5] > sums_in[4]) ? {sums_in[5], 3'd5} : {sums_in[4], 3'd4};
		end
		if (rdy_s5 && vld_s4) begin
			cls_s5  <= cls_s4;
			last_s5 <= last_s4;
			{w_s5, iw_s5} <= (b_s4 > a_s4) ? {b_s4, ib_s4} : {a_s4, ia_s4};
			c_s5  <= c_s4;
			ic_s5 <= ic_s4;
		end
		if (rdy_s6 && vld_s5) begin
			cls_s6  <= cls_s5;
			last_s6 <= last_s5;
			dom_s6  <= last_s5 ? win_c + 3'd1 : 3'd0;
		end
	end

endmodule
`default_nettype wire

/* rtl/hsv_dominant_color_classifier.sv */
// Top level of the HSV dominant color classifier: config registers, pipeline, recolor.
// Depends on hdc_pkg, hdc_classify, hdc_accum and hdc_argmax.
//
//  channel   direction  handshake            word
//  pixel     in         in_valid / in_stall  hue, saturation, brightness, frame_end
//  result    out        out_valid/out_stall  color_class, out_hue, out_saturation,
//                                            out_brightness, frame_done, dominant_color
//  config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; each word passes through the input
// register, classify, accumulate and three compare stages ending in the output register.
// Reset loads the default limits, clears the six class sums and empties the pipeline.
// out_stall holds the output register; empty stages behind it still fill, and in_stall
// rises only once all six stages hold a word. cfg_ready is always high.
`default_nettype none
module hsv_dominant_color_classifier
	import hdc_pkg::*;
#(
	parameter int FRAME_PIXEL_BITS = FRAME_PIXEL_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] hue,
	input  wire logic [7:0] saturation,
	input  wire logic [7:0] brightness,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      color_class,
	output logic [7:0]      out_hue,
	output logic [7:0]      out_saturation,
	output logic [7:0]      out_brightness,
	output logic            frame_done,
	output logic [2:0]      dominant_color,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int SUM_BITS = 16 + FRAME_PIXEL_BITS;

	cfg_t        cfg_q;
	logic        in_rdy;
	logic        vld_s2, rdy_s2n;
	color_t      cls_s2;
	logic [15:0] weight_s2;
	logic        last_s2;
	logic        vld_s3, rdy_s3n;
	color_t      cls_s3;
	logic        last_s3;
	logic [NUM_HUE_CLASSES-1:0][SUM_BITS-1:0] sums_s3;
	color_t      cls_s6;
	logic        last_s6;
	logic [2:0]  dom_s6;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_value_limit       <= DARK_VALUE_LIMIT_RST;
			cfg_q.saturation_line_offset <= SATURATION_LINE_OFFSET_RST;
			cfg_q.white_value_limit      <= WHITE_VALUE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DARK_VALUE_LIMIT:       cfg_q.dark_value_limit       <= cfg_data;
				REG_SATURATION_LINE_OFFSET: cfg_q.saturation_line_offset <= cfg_data;
				REG_WHITE_VALUE_LIMIT:      cfg_q.white_value_limit      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = !in_rdy;

	hdc_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_vld     (in_valid),
		.in_rdy     (in_rdy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.frame_end  (frame_end),
		.vld_s2     (vld_s2),
		.rdy_next   (rdy_s2n),
		.cls_s2     (cls_s2),
		.weight_s2  (weight_s2),
		.last_s2    (last_s2)
	);

	hdc_accum #(
		.SUM_BITS (SUM_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (vld_s2),
		.rdy_in    (rdy_s2n),
		.cls_in    (cls_s2),
		.weight_in (weight_s2),
		.last_in   (last_s2),
		.vld_s3    (vld_s3),
		.rdy_next  (rdy_s3n),
		.cls_s3    (cls_s3),
		.last_s3   (last_s3),
		.sums_s3   (sums_s3)
	);

	hdc_argmax #(
		.SUM_BITS (SUM_BITS)
	) u_argmax (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s3),
		.rdy_in   (rdy_s3n),
		.cls_in   (cls_s3),
		.last_in  (last_s3),
		.sums_in  (sums_s3),
		.vld_s6   (out_valid),
		.rdy_next (!out_stall),
		.cls_s6   (cls_s6),
		.last_s6  (last_s6),
		.dom_s6   (dom_s6)
	);

	// recolor from the registered class
	assign color_class    = 3'(cls_s6);
	assign out_hue        = class_hue(cls_s6);
	assign out_saturation = (cls_s6 == CLS_WHITE) ? 8'd0 : 8'd255;
	assign out_brightness = (cls_s6 == CLS_BLACK) ? 8'd0 : 8'd255;
	assign frame_done     = last_s6;
	assign dominant_color = dom_s6;

endmodule
`default_nettype wire

/* verif/hdc_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the HSV dominant color classifier testbench: predicts each output word.
// Depends on hdc_pkg for the class codes, register indexes and reset limits.
package hdc_tb_pkg;
	import hdc_pkg::*;

	// a narrow frame counter keeps the class sums small enough to saturate in a short run
	localparam int TB_PIXEL_BITS = 8;
	localparam int TB_SUM_BITS   = 16 + TB_PIXEL_BITS;
	localparam int MAX_REPORTS   = 10;

	// index with no register behind it
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		color_t     cls;
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] bri;
		logic       done;
		logic [2:0] dom;
	} pixel_word_t;

	class color_scoreboard;
		logic [7:0]             dark_limit;
		logic [7:0]             line_offset;
		logic [7:0]             white_limit;
		logic [TB_SUM_BITS-1:0] class_sums [NUM_HUE_CLASSES];
		pixel_word_t            expected_words [$];
		int                     mismatches;
		int                     words_checked;
		int                     frames_checked;
		int                     clipped_adds;

		function new();
			dark_limit     = DARK_VALUE_LIMIT_RST;
			line_offset    = SATURATION_LINE_OFFSET_RST;
			white_limit    = WHITE_VALUE_LIMIT_RST;
			foreach (class_sums[i]) class_sums[i] = '0;
			mismatches     = 0;
			words_checked  = 0;
			frames_checked = 0;
			clipped_adds   = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [7:0] value);
			case (index)
				REG_DARK_VALUE_LIMIT:       dark_limit  = value;
				REG_SATURATION_LINE_OFFSET: line_offset = value;
				REG_WHITE_VALUE_LIMIT:      white_limit = value;
				default: ;
			endcase
		endfunction

		function color_t hue_to_class(logic [7:0] h);
			if (h <= HUE_RED_LO_MAX)  return CLS_RED;
			if (h <= HUE_YELLOW_MAX)  return CLS_YELLOW;
			if (h <= HUE_GREEN_MAX)   return CLS_GREEN;
			if (h <= HUE_CYAN_MAX)    return CLS_CYAN;
			if (h <= HUE_BLUE_MAX)    return CLS_BLUE;
			if (h <= HUE_MAGENTA_MAX) return CLS_MAGENTA;
			return CLS_RED;
		endfunction

		function void note_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic last);
			color_t               c;
			pixel_word_t          w;
			logic [15:0]          weight;
			logic [TB_SUM_BITS:0] total;
			int                   k;
			int                   best;
			if (v <= dark_limit)
				c = CLS_BLACK;
			else if (3 * int'(s) + int'(v) > 3 * int'(line_offset))
				c = hue_to_class(h);
			else
				c = (v > white_limit) ? CLS_WHITE : CLS_BLACK;

			if (c != CLS_BLACK && c != CLS_WHITE) begin
				k      = int'(c) - 1;
				weight = s * v;
				total  = {1'b0, class_sums[k]} + weight;
				if (total[TB_SUM_BITS]) begin
					class_sums[k] = '1;
					clipped_adds++;
				end else begin
					class_sums[k] = total[TB_SUM_BITS-1:0];
				end
			end

			w.cls  = c;
			case (c)
				CLS_BLUE:    w.hue = 8'd170;
				CLS_GREEN:   w.hue = 8'd85;
				CLS_CYAN:    w.hue = 8'd128;
				CLS_MAGENTA: w.hue = 8'd213;
				CLS_YELLOW:  w.hue = 8'd43;
				default:     w.hue = 8'd0;
			endcase
			w.sat  = (c == CLS_WHITE) ? 8'd0 : 8'd255;
			w.bri  = (c == CLS_BLACK) ? 8'd0 : 8'd255;
			w.done = last;
			w.dom  = 3'd0;
			if (last) begin
				// lowest code wins ties: only a strictly larger sum moves the pick
				best = 0;
				for (int i = 1; i < NUM_HUE_CLASSES; i++)
					if (class_sums[i] > class_sums[best]) best = i;
				w.dom = 3'(best + 1);
				foreach (class_sums[i]) class_sums[i] = '0;
			end
			expected_words.push_back(w);
		endfunction

		function void check_word(pixel_word_t got);
			pixel_word_t want;
			bit          bad;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected word: class %0d hue %0d sat %0d bri %0d done %0b dom %0d",
						$time, got.cls, got.hue, got.sat, got.bri, got.done, got.dom);
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (want.done) frames_checked++;
			bad = (got.cls !== want.cls) || (got.hue !== want.hue) || (got.sat !== want.sat) ||
				(got.bri !== want.bri) || (got.done !== want.done) || (got.dom !== want.dom);
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: word %0d expected class %0d hue %0d sat %0d bri %0d done %0b dom %0d",
						$time, words_checked, want.cls, want.hue, want.sat, want.bri, want.done,
						want.dom);
					$display("%0t: word %0d got      class %0d hue %0d sat %0d bri %0d done %0b dom %0d",
						$time, words_checked, got.cls, got.hue, got.sat, got.bri, got.done, got.dom);
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

endpackage

/* verif/tb_hsv_dominant_color_classifier.sv */
`timescale 1ns / 1ps
// Top of the HSV dominant color classifier testbench: clock, reset, drivers and monitor.
// Depends on hdc_pkg, hdc_tb_pkg and the hsv_dominant_color_classifier RTL.
module tb_hsv_dominant_color_classifier;
	import hdc_pkg::*;
	import hdc_tb_pkg::*;

	localparam int PHASE_PIXELS = 150;
	localparam int NUM_PHASES   = 7;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int HEAVY_PIXELS = 540;

	localparam logic [7:0] BAND_TOPS [6] = '{HUE_RED_LO_MAX, HUE_YELLOW_MAX, HUE_GREEN_MAX,
		HUE_CYAN_MAX, HUE_BLUE_MAX, HUE_MAGENTA_MAX};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic       frame_end;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] color_class;
	logic [7:0] out_hue;
	logic [7:0] out_saturation;
	logic [7:0] out_brightness;
	logic       frame_done;
	logic [2:0] dominant_color;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	color_scoreboard sb;
	int in_idle_pct;
	int stall_pct;
	int hold_ask = 0;
	int hold_seen;
	int stall_cycles = 0;
	int settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hsv_dominant_color_classifier #(
		.FRAME_PIXEL_BITS(TB_PIXEL_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.hue           (hue),
		.saturation    (saturation),
		.brightness    (brightness),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.color_class   (color_class),
		.out_hue       (out_hue),
		.out_saturation(out_saturation),
		.out_brightness(out_brightness),
		.frame_done    (frame_done),
		.dominant_color(dominant_color),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic int run_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int frame_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 1;
		if (r < 75) return $urandom_range(2, 24);
		if (r < 95) return $urandom_range(25, 80);
		return $urandom_range(81, 200);
	endfunction

	function automatic logic [7:0] clip8(int x);
		if (x < 0) return 8'd0;
		if (x > 255) return 8'd255;
		return x[7:0];
	endfunction

	// sample at the edge: inputs and outputs both still hold their pre-edge values here
	always @(posedge clk) begin
		pixel_word_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.cls  = color_t'(color_class);
				got.hue  = out_hue;
				got.sat  = out_saturation;
				got.bri  = out_brightness;
				got.done = frame_done;
				got.dom  = dominant_color;
				sb.check_word(got);
			end
			if (in_valid && !in_stall)
				sb.note_pixel(hue, saturation, brightness, frame_end);
			if (in_valid && in_stall)
				stall_cycles++;
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// result side: random stall runs, plus a long hold whenever the main flow asks for one
	initial begin
		int run;
		out_stall = 1'b0;
		run       = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				run = run_length();
			end
		end
	end

	task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
		input logic last);
		int gap;
		gap = ($urandom_range(0, 99) < in_idle_pct) ? run_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		frame_end  <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_limits(input logic [7:0] dark, input logic [7:0] offset,
		input logic [7:0] white);
		write_register(REG_DARK_VALUE_LIMIT, dark);
		write_register(REG_SATURATION_LINE_OFFSET, offset);
		write_register(REG_WHITE_VALUE_LIMIT, white);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// drop valid, then wait out every word still owed by the block
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// bias toward the dark, saturation-line and white thresholds of the current limits
	task automatic random_pixel(output logic [7:0] h, output logic [7:0] s, output logic [7:0] v);
		int pick;
		pick = $urandom_range(0, 9);
		h = 8'($urandom_range(0, 255));
		s = 8'($urandom_range(0, 255));
		v = 8'($urandom_range(0, 255));
		case (pick)
			5: v = clip8(int'(sb.dark_limit) + int'($urandom_range(0, 4)) - 2);
			6: s = clip8((3 * int'(sb.line_offset) - int'(v)) / 3 + int'($urandom_range(0, 2)) - 1);
			7: begin
				s = 8'($urandom_range(0, 40));
				v = clip8(int'(sb.white_limit) + int'($urandom_range(0, 4)) - 2);
			end
			8: begin
				h = BAND_TOPS[$urandom_range(0, 5)] + 8'($urandom_range(0, 1));
				s = 8'd255;
				v = 8'd255;
			end
			9: begin
				s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				v = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: ;
		endcase
	endtask

	task automatic run_frames(input int pixels);
		int         sent;
		int         len;
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		sent = 0;
		while (sent < pixels) begin
			len = frame_length();
			for (int i = 0; i < len; i++) begin
				random_pixel(h, s, v);
				send_pixel(h, s, v, i == len - 1);
			end
			sent += len;
		end
	endtask

	// green and magenta both clip at full scale, so the tie goes to green
	task automatic saturating_frame();
		for (int i = 0; i < HEAVY_PIXELS; i++)
			send_pixel(i[0] ? 8'd200 : 8'd85, 8'd255, 8'd255, i == HEAVY_PIXELS - 1);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		hue         = 8'd0;
		saturation  = 8'd0;
		brightness  = 8'd0;
		frame_end   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_DARK_VALUE_LIMIT;
		cfg_data    = 8'd0;
		in_idle_pct = 0;
		stall_pct   = 0;
		sb          = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset limits
		send_pixel(8'd100, 8'd255, 8'd45, 1'b1);   // dark at the limit, empty frame
		send_pixel(8'd0, 8'd255, 8'd46, 1'b0);
		send_pixel(8'd15, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd16, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd51, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd52, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd97, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd98, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd143, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd144, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd182, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd183, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd230, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd231, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd200, 8'd98, 8'd46, 1'b0);    // just over the saturation line
		send_pixel(8'd200, 8'd97, 8'd46, 1'b0);    // just under, dim
		send_pixel(8'd200, 8'd58, 8'd165, 1'b0);   // on the line, bright
		send_pixel(8'd200, 8'd58, 8'd166, 1'b0);
		send_pixel(8'd200, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd200, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd120, 8'd255, 8'd255, 1'b1);  // single-pixel frame
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin in_idle_pct = 0;  stall_pct = 0;  end
				1: begin
					write_limits(8'd0, 8'd0, 8'd0);
					in_idle_pct = 20; stall_pct = 30;
				end
				2: begin
					write_register(REG_UNUSED, 8'($urandom_range(0, 255)));
					write_limits(8'd255, 8'd255, 8'd255);
					in_idle_pct = 50; stall_pct = 10;
				end
				3: begin
					write_limits(DARK_VALUE_LIMIT_RST, SATURATION_LINE_OFFSET_RST,
						WHITE_VALUE_LIMIT_RST);
					in_idle_pct = 10; stall_pct = 50;
				end
				4: begin
					write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
					in_idle_pct = 30; stall_pct = 30;
				end
				5: begin
					write_limits(8'd100, 8'd30, 8'd250);
					in_idle_pct = 5;  stall_pct = 70;
				end
				default: begin
					write_limits(8'($urandom_range(0, 120)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
					in_idle_pct = 40; stall_pct = 40;
				end
			endcase
			// hold the result side off while pixels keep coming, so in_stall has to rise
			if (p == 1 || p == 4) hold_ask++;
			run_frames(PHASE_PIXELS);
			if (p == 3) saturating_frame();
			drain();
		end

		$display("covered %0d pixels in %0d frames over %0d written limit sets plus reset limits",
			sb.words_checked, sb.frames_checked, settings_used);
		$display("%0d clipped sum updates, %0d cycles of a waiting pixel held by in_stall",
			sb.clipped_adds, stall_cycles);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[hsv_dominant_color_classifier] OK");
		end else begin
			$display("[hsv_dominant_color_classifier] ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[hsv_dominant_color_classifier] ERROR");
		$finish;
	end

endmodule
